### src/des_pkg.sv
package des_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int ENTRY_BYTES  = 32;
    localparam int SLOT_W       = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [7:0] MARK_END       = 8'h00;
    localparam logic [7:0] MARK_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FRONT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TAIL  = 2'd1;

    localparam logic [2:0] STATUS_CONTINUE  = 3'd0;
    localparam logic [2:0] STATUS_FOUND     = 3'd1;
    localparam logic [2:0] STATUS_END       = 3'd2;
    localparam logic [2:0] STATUS_EXHAUSTED = 3'd3;
    localparam logic [2:0] STATUS_IDLE      = 3'd4;

    typedef struct packed {
        logic              begin_search;
        logic              last_of_directory;
        logic [31:0]       entry_sector;
        logic [SLOT_W-1:0] entry_slot;
        logic [63:0]       entry_name_front;
        logic [23:0]       entry_name_tail;
        logic [7:0]        entry_attributes;
        logic [15:0]       entry_cluster_upper;
        logic [15:0]       entry_cluster_lower;
        logic [31:0]       entry_length;
    } entry_t;

    typedef struct packed {
        logic [2:0]        search_status;
        logic [31:0]       found_cluster;
        logic [7:0]        found_attributes;
        logic [31:0]       found_length;
        logic [31:0]       found_sector;
        logic [SLOT_W-1:0] found_slot;
        logic              free_known;
        logic [31:0]       free_sector_out;
        logic [SLOT_W-1:0] free_slot_out;
    } result_t;

    // Entry after classification, as it waits between the two halves.
    typedef struct packed {
        logic              begin_search;
        logic              last_of_directory;
        logic              is_end;
        logic              is_free;
        logic              is_match;
        logic [31:0]       sector;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       cluster;
        logic [7:0]        attributes;
        logic [31:0]       length;
    } class_item_t;

endpackage

### src/des_front.sv
module des_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  des_pkg::entry_t       entry,
    input  logic [63:0]           target_front,
    input  logic [23:0]           target_tail,
    output logic                  mid_empty,
    input  logic                  mid_pop,
    output des_pkg::class_item_t  mid_item
);
    import des_pkg::*;

    class_item_t       cls;
    class_item_t       mem [QUEUE_DEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        cls.begin_search      = entry.begin_search;
        cls.last_of_directory = entry.last_of_directory;
        cls.is_end            = (entry.entry_name_front[7:0] == MARK_END);
        cls.is_free           = (entry.entry_name_front[7:0] == MARK_DELETED) ||
                                (entry.entry_attributes == ATTR_LONG_NAME);
        cls.is_match          = (entry.entry_name_front == target_front) &&
                                (entry.entry_name_tail == target_tail);
        cls.sector            = entry.entry_sector;
        cls.slot              = entry.entry_slot;
        cls.cluster           = {entry.entry_cluster_upper, entry.entry_cluster_lower};
        cls.attributes        = entry.entry_attributes;
        cls.length            = entry.entry_length;
    end

    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign mid_empty = (count_reg == 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = mid_pop && !mid_empty;
    assign mid_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/des_back.sv
module des_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mid_empty,
    output logic                  mid_pop,
    input  des_pkg::class_item_t  mid_item,
    output logic                  empty,
    input  logic                  pop,
    output des_pkg::result_t      result
);
    import des_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic              seen_reg;
    logic              seen_next;
    logic [31:0]       kept_sector_reg;
    logic [31:0]       kept_sector_next;
    logic [SLOT_W-1:0] kept_slot_reg;
    logic [SLOT_W-1:0] kept_slot_next;
    result_t           res;
    result_t           mem [QUEUE_DEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              out_full;
    logic              do_step;
    logic              do_pop;

    assign out_full = (count_reg == 2'(QUEUE_DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign do_step  = !mid_empty && !out_full;
    assign mid_pop  = do_step;
    assign do_pop   = pop && !empty;
    assign result   = mem[rd_ptr_reg];

    always_comb
    begin
        active_next      = mid_item.begin_search ? 1'b1 : active_reg;
        seen_next        = mid_item.begin_search ? 1'b0 : seen_reg;
        kept_sector_next = mid_item.begin_search ? 32'd0 : kept_sector_reg;
        kept_slot_next   = mid_item.begin_search ? '0 : kept_slot_reg;
        res              = '0;

        if (!active_next)
        begin
            res.search_status = STATUS_IDLE;
        end
        else
        begin
            if ((mid_item.is_end || mid_item.is_free) && !seen_next)
            begin
                seen_next        = 1'b1;
                kept_sector_next = mid_item.sector;
                kept_slot_next   = mid_item.slot;
            end

            if (mid_item.is_end)
            begin
                res.search_status = STATUS_END;
                active_next       = 1'b0;
            end
            else if (!mid_item.is_free && mid_item.is_match)
            begin
                res.search_status    = STATUS_FOUND;
                res.found_cluster    = mid_item.cluster;
                res.found_attributes = mid_item.attributes;
                res.found_length     = mid_item.length;
                res.found_sector     = mid_item.sector;
                res.found_slot       = mid_item.slot;
                active_next          = 1'b0;
            end
            else if (mid_item.last_of_directory)
            begin
                res.search_status = STATUS_EXHAUSTED;
                active_next       = 1'b0;
            end
            else
            begin
                res.search_status = STATUS_CONTINUE;
            end

            if (seen_next)
            begin
                res.free_known      = 1'b1;
                res.free_sector_out = kept_sector_next;
                res.free_slot_out   = kept_slot_next;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_step && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_step)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            seen_reg        <= 1'b0;
            kept_sector_reg <= 32'd0;
            kept_slot_reg   <= '0;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
        end
        else
        begin
            if (do_step)
            begin
                active_reg      <= active_next;
                seen_reg        <= seen_next;
                kept_sector_reg <= kept_sector_next;
                kept_slot_reg   <= kept_slot_next;
                wr_ptr_reg      <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### src/directory_entry_search.sv
// Short-name lookup over a stream of 32-byte directory entries.
// Write the target name through the configuration channel (index 0 for
// bytes 0 to 7, index 1 for bytes 8 to 10) while no search is in flight;
// cfg_ready is always high.
// Entries enter as items through push and full, one per cycle while full
// is low; the item that starts a search carries begin_search. Every item
// gives exactly one result item, read through empty and pop in input order.
// An entry is classified on the cycle it is accepted and waits in a
// two-entry queue; the search state updates as it leaves that queue, and
// the result lands in a two-entry output queue. A result is registered in
// the output queue after its item has passed through the classified queue,
// and one item per cycle is sustained as long as results are popped at
// that rate.
// When results are not popped, the output queue fills, the classified
// queue behind it fills, and full rises; nothing is dropped.
// Reset clears both queues, ends any search and sets the target name to
// zero.
module directory_entry_search
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  des_pkg::entry_t                      entry,
    output logic                                 empty,
    input  logic                                 pop,
    output des_pkg::result_t                     result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [des_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [63:0]                          cfg_data
);
    import des_pkg::*;

    logic [63:0]  target_front_reg;
    logic [23:0]  target_tail_reg;
    logic         mid_empty;
    logic         mid_pop;
    class_item_t  mid_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_front_reg <= 64'd0;
            target_tail_reg  <= 24'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET_FRONT: target_front_reg <= cfg_data;
                REG_TARGET_TAIL:  target_tail_reg  <= cfg_data[23:0];
                default:          ;
            endcase
        end
    end

    des_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .entry        (entry),
        .target_front (target_front_reg),
        .target_tail  (target_tail_reg),
        .mid_empty    (mid_empty),
        .mid_pop      (mid_pop),
        .mid_item     (mid_item)
    );

    des_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_item  (mid_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
